[src/aabb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_pkg
// shared types and constants of the box table and collision pass
// ----------------------------------------------------------------------------
package aabb_pkg;

  localparam int MAX_BOXES_DEF = 64;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam int FLAG_STATIC = 0;
  localparam int FLAG_BOUNCE = 1;
  localparam int FLAG_COLX   = 2;
  localparam int FLAG_COLY   = 3;

  typedef struct packed {
    logic [3:0]         flags;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_x;
    logic [30:0]        size_h;
    logic [30:0]        size_w;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } entry_t;

endpackage
`default_nettype wire

[src/aabb_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module aabb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/aabb_move_and_collide_pass.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_move_and_collide_pass
// box table with one axis-separated move and collide pass per step command
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A write command
// loads one entry and gives no result. A read command gives one result on
// the cycle after it is taken, and busy stays low. A step command holds busy
// while it walks entries 0 to count-1 through the entry ram: a skipped box
// (static or zero velocity) passes through fetch and setup only, and a moving
// box passes through fetch, setup, bounds, a scan of count ram reads, pipeline
// drain and write back, as the scan reads one entry a cycle from the single
// ram read port. Then count results follow on consecutive cycles, the last
// marked by out_last_result, the first in the cycle after the emit reads begin.
// Each result stands for exactly one cycle with out_valid high; the receiver
// cannot stall. Reset returns the control to idle; the table contents are
// undefined until written, and no clearing pass is run.
// ----------------------------------------------------------------------------
module aabb_move_and_collide_pass #(
  parameter int MAX_BOXES = aabb_pkg::MAX_BOXES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_command,
  input  wire logic [5:0]  in_entry_index,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic [30:0] in_size_w,
  input  wire logic [30:0] in_size_h,
  input  wire logic signed [31:0] in_vel_x,
  input  wire logic signed [31:0] in_vel_y,
  input  wire logic        in_is_static,
  input  wire logic        in_bounces,
  input  wire logic [6:0]  in_entry_count,
  output logic             out_valid,
  output logic [5:0]       out_index,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic             out_blocked_x,
  output logic             out_blocked_y,
  output logic             out_last_result
);

  localparam int IDX_W = $clog2(MAX_BOXES);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int EW    = $bits(aabb_pkg::entry_t);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FETCH = 8'b0000_0010,
    S_SETUP = 8'b0000_0100,
    S_PREP  = 8'b0000_1000,
    S_SCAN  = 8'b0001_0000,
    S_DRAIN = 8'b0010_0000,
    S_WB    = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] i_r, j_r, k_r, count_r, j1_r, j2_r;
  logic             v1_r, v2_r;
  aabb_pkg::entry_t cur_r, rd, wb_entry, new_entry;
  logic signed [31:0] nx_r, ny_r;
  logic signed [33:0] xln_r, xhn_r, xlo_r, xho_r, yln_r, yhn_r, ylo_r, yho_r;
  logic signed [33:0] jxl_r, jxh_r, jyl_r, jyh_r;
  logic             free_x_r, free_y_r;
  logic             out_valid_r, out_last_r, out_zero_r;
  logic [5:0]       out_idx_r;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [EW-1:0]    rdata;
  logic [31:0]      idx32, cnt32, cnt_sat, k32;
  logic             idx_ok, skip, last_i, last_k;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] a);
    neg_sat = (a == 32'sh8000_0000) ? 32'sh7fff_ffff : -a;
  endfunction

  function automatic logic signed [33:0] edge_lo(input logic signed [31:0] c,
                                                 input logic [30:0] s);
    edge_lo = (34'(c) <<< 1) - $signed({3'b000, s});
  endfunction

  function automatic logic signed [33:0] edge_hi(input logic signed [31:0] c,
                                                 input logic [30:0] s);
    edge_hi = (34'(c) <<< 1) + $signed({3'b000, s});
  endfunction

  assign rd      = aabb_pkg::entry_t'(rdata);
  assign idx32   = 32'(in_entry_index);
  assign idx_ok  = idx32 < 32'(MAX_BOXES);
  assign cnt32   = 32'(in_entry_count);
  assign cnt_sat = (cnt32 > 32'(MAX_BOXES)) ? 32'(MAX_BOXES) : cnt32;
  assign k32     = 32'(k_r);
  assign skip    = ((rd.vel_x == 32'sd0) && (rd.vel_y == 32'sd0)) ||
                   rd.flags[aabb_pkg::FLAG_STATIC];
  assign last_i  = (i_r == count_r - CNT_W'(1));
  assign last_k  = (k_r == count_r - CNT_W'(1));

  always_comb begin
    new_entry = '0;
    new_entry.pos_x  = in_pos_x;
    new_entry.pos_y  = in_pos_y;
    new_entry.size_w = in_size_w;
    new_entry.size_h = in_size_h;
    new_entry.vel_x  = in_vel_x;
    new_entry.vel_y  = in_vel_y;
    new_entry.flags[aabb_pkg::FLAG_STATIC] = in_is_static;
    new_entry.flags[aabb_pkg::FLAG_BOUNCE] = in_bounces;
  end

  always_comb begin
    wb_entry = cur_r;
    wb_entry.flags[aabb_pkg::FLAG_COLX] = !free_x_r;
    wb_entry.flags[aabb_pkg::FLAG_COLY] = !free_y_r;
    if (free_x_r) begin
      wb_entry.pos_x = nx_r;
    end else if (cur_r.flags[aabb_pkg::FLAG_BOUNCE]) begin
      wb_entry.vel_x = neg_sat(cur_r.vel_x);
    end
    if (free_y_r) begin
      wb_entry.pos_y = ny_r;
    end else if (cur_r.flags[aabb_pkg::FLAG_BOUNCE]) begin
      wb_entry.vel_y = neg_sat(cur_r.vel_y);
    end
  end

  always_comb begin
    state_nxt = state_r;
    we        = 1'b0;
    waddr     = i_r[IDX_W-1:0];
    raddr     = i_r[IDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_command)
            aabb_pkg::CMD_WRITE: begin
              we    = idx_ok;
              waddr = idx32[IDX_W-1:0];
            end
            aabb_pkg::CMD_READ: begin
              raddr = idx32[IDX_W-1:0];
            end
            aabb_pkg::CMD_STEP: begin
              if (cnt_sat != 32'd0) state_nxt = S_FETCH;
            end
            default: ;
          endcase
        end
      end
      S_FETCH: state_nxt = S_SETUP;
      S_SETUP: begin
        if (!skip) state_nxt = S_PREP;
        else if (last_i) state_nxt = S_EMIT;
        else state_nxt = S_FETCH;
      end
      S_PREP: state_nxt = S_SCAN;
      S_SCAN: begin
        raddr = j_r[IDX_W-1:0];
        if (j_r == count_r - CNT_W'(1)) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!v1_r && !v2_r) state_nxt = S_WB;
      end
      S_WB: begin
        we        = 1'b1;
        state_nxt = last_i ? S_EMIT : S_FETCH;
      end
      S_EMIT: begin
        raddr = k_r[IDX_W-1:0];
        if (last_k) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  aabb_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_BOXES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ((state_r == S_IDLE) ? new_entry : wb_entry),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      v1_r        <= (state_r == S_SCAN);
      v2_r        <= v1_r;
      out_valid_r <= ((state_r == S_IDLE) && start && (in_command == aabb_pkg::CMD_READ)) ||
                     (state_r == S_EMIT);
      case (state_r)
        S_IDLE: begin
          if (start && (in_command == aabb_pkg::CMD_STEP)) begin
            count_r <= cnt_sat[CNT_W-1:0];
            i_r     <= '0;
          end
        end
        S_SETUP: begin
          if (skip) begin
            i_r <= i_r + CNT_W'(1);
            k_r <= '0;
          end
        end
        S_PREP: j_r <= '0;
        S_SCAN: j_r <= j_r + CNT_W'(1);
        S_WB: begin
          i_r <= i_r + CNT_W'(1);
          k_r <= '0;
        end
        S_EMIT: k_r <= k_r + CNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    j1_r <= j_r;
    j2_r <= j1_r;
    if (state_r == S_SETUP) begin
      cur_r <= rd;
      nx_r  <= sat_add(rd.pos_x, rd.vel_x);
      ny_r  <= sat_add(rd.pos_y, rd.vel_y);
    end
    if (state_r == S_PREP) begin
      xln_r    <= edge_lo(nx_r, cur_r.size_w);
      xhn_r    <= edge_hi(nx_r, cur_r.size_w);
      xlo_r    <= edge_lo(cur_r.pos_x, cur_r.size_w);
      xho_r    <= edge_hi(cur_r.pos_x, cur_r.size_w);
      yln_r    <= edge_lo(ny_r, cur_r.size_h);
      yhn_r    <= edge_hi(ny_r, cur_r.size_h);
      ylo_r    <= edge_lo(cur_r.pos_y, cur_r.size_h);
      yho_r    <= edge_hi(cur_r.pos_y, cur_r.size_h);
      free_x_r <= 1'b1;
      free_y_r <= 1'b1;
    end
    if (v1_r) begin
      jxl_r <= edge_lo(rd.pos_x, rd.size_w);
      jxh_r <= edge_hi(rd.pos_x, rd.size_w);
      jyl_r <= edge_lo(rd.pos_y, rd.size_h);
      jyh_r <= edge_hi(rd.pos_y, rd.size_h);
    end
    if (v2_r && (j2_r != i_r)) begin
      if ((xln_r <= jxh_r) && (xhn_r >= jxl_r) && (ylo_r <= jyh_r) && (yho_r >= jyl_r))
        free_x_r <= 1'b0;
      if ((xlo_r <= jxh_r) && (xho_r >= jxl_r) && (yln_r <= jyh_r) && (yhn_r >= jyl_r))
        free_y_r <= 1'b0;
    end
    if (state_r == S_IDLE) begin
      out_idx_r  <= in_entry_index;
      out_last_r <= 1'b1;
      out_zero_r <= !idx_ok;
    end else begin
      out_idx_r  <= k32[5:0];
      out_last_r <= last_k;
      out_zero_r <= 1'b0;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_index       = out_idx_r;
  assign out_last_result = out_last_r;
  assign out_pos_x       = out_zero_r ? 32'sd0 : rd.pos_x;
  assign out_pos_y       = out_zero_r ? 32'sd0 : rd.pos_y;
  assign out_vel_x       = out_zero_r ? 32'sd0 : rd.vel_x;
  assign out_vel_y       = out_zero_r ? 32'sd0 : rd.vel_y;
  assign out_blocked_x   = !out_zero_r && rd.flags[aabb_pkg::FLAG_COLX];
  assign out_blocked_y   = !out_zero_r && rd.flags[aabb_pkg::FLAG_COLY];

`ifndef SYNTH
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) || (state_r == S_DRAIN) || (state_r == S_EMIT)) |-> !we)
    else $error("ram written during scan or emit");
  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> $past(v1_r))
    else $error("compare stage without read stage");
  a_wb_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |-> (!v1_r && !v2_r && $past(state_r == S_DRAIN)))
    else $error("write back before scan drained");
`endif

endmodule
`default_nettype wire

[tb/sv/aabb_move_and_collide_pass_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_move_and_collide_pass_tb
// self-checking bench for the box table and collision pass
// ----------------------------------------------------------------------------
// Commands are sent in random bursts. Each accepted transaction goes through
// a behavioural model of the box table that predicts every entry reported by
// a read or a step. Results are checked field by field in arrival order.
// Directed tests cover touching edges, bounce, saturation and skipped boxes.
// Random tests run well-formed tables and a full 64-entry pass.
// ----------------------------------------------------------------------------
module aabb_move_and_collide_pass_tb;

  localparam int NBOX = aabb_pkg::MAX_BOXES_DEF;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;

  typedef struct {
    logic [1:0]         cmd;
    logic [5:0]         idx;
    logic signed [31:0] px, py, vx, vy;
    logic [30:0]        w, h;
    logic               st, bn;
    logic [6:0]         cnt;
  } box_cmd_t;

  typedef struct {
    logic [5:0]         idx;
    logic signed [31:0] px, py, vx, vy;
    logic               bx, by, last;
  } box_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_command = '0;
  logic [5:0] in_entry_index = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_vel_x = '0, in_vel_y = '0;
  logic [30:0] in_size_w = '0, in_size_h = '0;
  logic in_is_static = 1'b0, in_bounces = 1'b0;
  logic [6:0] in_entry_count = '0;
  logic out_valid, out_blocked_x, out_blocked_y, out_last_result;
  logic [5:0] out_index;
  logic signed [31:0] out_pos_x, out_pos_y, out_vel_x, out_vel_y;

  // model state
  logic signed [31:0] box_px [NBOX], box_py [NBOX], box_vx [NBOX], box_vy [NBOX];
  logic [30:0]        box_w [NBOX], box_h [NBOX];
  logic [3:0]         box_flags [NBOX];
  bit                 box_written [NBOX];

  box_report_t expected_reports [$];
  int mismatches = 0;
  int items_sent = 0;
  int reports_seen = 0;
  int steps_sent = 0;
  int burst_left = 0;

  aabb_move_and_collide_pass uut (
    .clk, .rst_n, .start, .busy, .in_command, .in_entry_index, .in_pos_x,
    .in_pos_y, .in_size_w, .in_size_h, .in_vel_x, .in_vel_y, .in_is_static,
    .in_bounces, .in_entry_count, .out_valid, .out_index, .out_pos_x,
    .out_pos_y, .out_vel_x, .out_vel_y, .out_blocked_x, .out_blocked_y,
    .out_last_result
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("timeout with %0d reports outstanding", expected_reports.size());
    $display("** aabb_move_and_collide_pass: FAILED **");
    $finish;
  end

  function automatic longint clamp32(longint v);
    if (v > S32_HI) return S32_HI;
    if (v < S32_LO) return S32_LO;
    return v;
  endfunction

  function automatic bit touches(longint x, longint y, longint w, longint h, int k);
    longint x2, y2, w2, h2;
    x2 = box_px[k];
    y2 = box_py[k];
    w2 = box_w[k];
    h2 = box_h[k];
    return (2 * x - w <= 2 * x2 + w2) && (2 * x + w >= 2 * x2 - w2) &&
           (2 * y - h <= 2 * y2 + h2) && (2 * y + h >= 2 * y2 - h2);
  endfunction

  function automatic box_report_t entry_report(int k, bit last);
    box_report_t r;
    r.idx = k[5:0];
    r.px = box_px[k];
    r.py = box_py[k];
    r.vx = box_vx[k];
    r.vy = box_vy[k];
    r.bx = box_flags[k][aabb_pkg::FLAG_COLX];
    r.by = box_flags[k][aabb_pkg::FLAG_COLY];
    r.last = last;
    return r;
  endfunction

  task automatic move_boxes(int count);
    longint x, y, w, h, nx, ny;
    bit free_x, free_y;
    for (int i = 0; i < count; i++) begin
      if ((box_vx[i] == 0 && box_vy[i] == 0) || box_flags[i][aabb_pkg::FLAG_STATIC])
        continue;
      x = box_px[i];
      y = box_py[i];
      w = box_w[i];
      h = box_h[i];
      nx = clamp32(x + longint'(box_vx[i]));
      ny = clamp32(y + longint'(box_vy[i]));
      free_x = 1'b1;
      free_y = 1'b1;
      for (int j = 0; j < count; j++) begin
        if (j == i) continue;
        if (free_x && touches(nx, y, w, h, j)) free_x = 1'b0;
        if (free_y && touches(x, ny, w, h, j)) free_y = 1'b0;
      end
      if (free_x) begin
        box_px[i] = nx[31:0];
        box_flags[i][aabb_pkg::FLAG_COLX] = 1'b0;
      end else begin
        box_flags[i][aabb_pkg::FLAG_COLX] = 1'b1;
        if (box_flags[i][aabb_pkg::FLAG_BOUNCE])
          box_vx[i] = 32'(clamp32(-longint'(box_vx[i])));
      end
      if (free_y) begin
        box_py[i] = ny[31:0];
        box_flags[i][aabb_pkg::FLAG_COLY] = 1'b0;
      end else begin
        box_flags[i][aabb_pkg::FLAG_COLY] = 1'b1;
        if (box_flags[i][aabb_pkg::FLAG_BOUNCE])
          box_vy[i] = 32'(clamp32(-longint'(box_vy[i])));
      end
    end
  endtask

  task automatic apply_command(box_cmd_t c);
    int count;
    case (c.cmd)
      aabb_pkg::CMD_WRITE: begin
        box_px[c.idx] = c.px;
        box_py[c.idx] = c.py;
        box_w[c.idx] = c.w;
        box_h[c.idx] = c.h;
        box_vx[c.idx] = c.vx;
        box_vy[c.idx] = c.vy;
        box_flags[c.idx] = '0;
        box_flags[c.idx][aabb_pkg::FLAG_STATIC] = c.st;
        box_flags[c.idx][aabb_pkg::FLAG_BOUNCE] = c.bn;
        box_written[c.idx] = 1'b1;
      end
      aabb_pkg::CMD_READ: expected_reports.push_back(entry_report(c.idx, 1'b1));
      aabb_pkg::CMD_STEP: begin
        count = (c.cnt > NBOX) ? NBOX : c.cnt;
        move_boxes(count);
        for (int k = 0; k < count; k++)
          expected_reports.push_back(entry_report(k, k == count - 1));
        steps_sent++;
      end
      default: ;
    endcase
  endtask

  // one transaction; returns at the rising edge that took it, or after an idle gap with start low when its burst ends
  task automatic send_command(box_cmd_t c);
    in_command <= c.cmd;
    in_entry_index <= c.idx;
    in_pos_x <= c.px;
    in_pos_y <= c.py;
    in_size_w <= c.w;
    in_size_h <= c.h;
    in_vel_x <= c.vx;
    in_vel_y <= c.vy;
    in_is_static <= c.st;
    in_bounces <= c.bn;
    in_entry_count <= c.cnt;
    start <= 1'b1;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    apply_command(c);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(0, 8);
    end
  endtask

  function automatic box_cmd_t make_cmd(logic [1:0] cmd, int idx);
    box_cmd_t c;
    c.cmd = cmd;
    c.idx = idx[5:0];
    c.px = '0;
    c.py = '0;
    c.vx = '0;
    c.vy = '0;
    c.w = '0;
    c.h = '0;
    c.st = 1'b0;
    c.bn = 1'b0;
    c.cnt = '0;
    return c;
  endfunction

  function automatic box_cmd_t make_box(int idx, int x, int y, int w, int h, int vx,
                                        int vy, bit st, bit bn);
    box_cmd_t c;
    c = make_cmd(aabb_pkg::CMD_WRITE, idx);
    c.px = x;
    c.py = y;
    c.w = w[30:0];
    c.h = h[30:0];
    c.vx = vx;
    c.vy = vy;
    c.st = st;
    c.bn = bn;
    return c;
  endfunction

  function automatic box_cmd_t make_step(int cnt);
    box_cmd_t c;
    c = make_cmd(aabb_pkg::CMD_STEP, 0);
    c.cnt = cnt[6:0];
    return c;
  endfunction

  // crowded small values mostly, so boxes actually meet
  function automatic box_cmd_t random_box(int idx);
    box_cmd_t c;
    c = make_cmd(aabb_pkg::CMD_WRITE, idx);
    if ($urandom_range(0, 5) == 0) begin
      c.px = $urandom;
      c.py = $urandom;
      c.w = 31'($urandom);
      c.h = 31'($urandom);
      c.vx = $urandom;
      c.vy = $urandom;
    end else begin
      c.px = $signed($urandom_range(0, 20 << 16)) - (10 << 16);
      c.py = $signed($urandom_range(0, 20 << 16)) - (10 << 16);
      c.w = 31'($urandom_range(0, 6 << 16));
      c.h = 31'($urandom_range(0, 6 << 16));
      c.vx = $signed($urandom_range(0, 6 << 16)) - (3 << 16);
      c.vy = $signed($urandom_range(0, 6 << 16)) - (3 << 16);
      if ($urandom_range(0, 5) == 0) c.vx = 0;
      if ($urandom_range(0, 5) == 0) c.vy = 0;
    end
    c.st = ($urandom_range(0, 4) == 0);
    c.bn = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic int written_prefix();
    int n;
    n = 0;
    while (n < NBOX && box_written[n]) n++;
    return n;
  endfunction

  always @(negedge clk) begin
    box_report_t e;
    if (rst_n && out_valid) begin
      reports_seen++;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected report for entry %0d", out_index);
      end else begin
        e = expected_reports.pop_front();
        if (out_index !== e.idx || out_pos_x !== e.px || out_pos_y !== e.py ||
            out_vel_x !== e.vx || out_vel_y !== e.vy || out_blocked_x !== e.bx ||
            out_blocked_y !== e.by || out_last_result !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp idx %0d pos %h,%h vel %h,%h blk %b%b last %b",
                      " | got idx %0d pos %h,%h vel %h,%h blk %b%b last %b"},
                     e.idx, e.px, e.py, e.vx, e.vy, e.bx, e.by, e.last,
                     out_index, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
                     out_blocked_x, out_blocked_y, out_last_result);
        end
      end
    end
  end

  task automatic test_edges_and_bounce();
    // touching edges block, bounce, position and negation saturation, skips
    send_command(make_box(0, 0, 0, 2 << 16, 2 << 16, 2 << 16, 0, 1'b0, 1'b1));
    send_command(make_box(1, 4 << 16, 0, 2 << 16, 2 << 16, 0, 0, 1'b1, 1'b0));
    send_command(make_box(2, 32'h7fff0000, 100 << 16, 2 << 16, 2 << 16,
                          32'h7fffffff, 32'h7fffffff, 1'b0, 1'b1));
    send_command(make_box(3, 32'ha0000000, -(50 << 16), 2 << 16, 2 << 16,
                          32'h80000000, 32'h80000000, 1'b0, 1'b1));
    send_command(make_box(4, 32'h80000000, -(50 << 16), 32'h7fffffff, 2 << 16,
                          0, 0, 1'b1, 1'b0));
    send_command(make_box(5, 20 << 16, 20 << 16, 1 << 16, 1 << 16, 5 << 16, 5 << 16,
                          1'b1, 1'b1));
    send_command(make_box(6, -(20 << 16), 20 << 16, 0, 0, 0, 0, 1'b0, 1'b0));
    send_command(make_box(7, 32'h55555555, 32'haaaaaaaa, 32'h7fffffff, 32'h7fffffff,
                          1 << 16, -(1 << 16), 1'b0, 1'b0));
    send_command(make_cmd(aabb_pkg::CMD_READ, 3));
    send_command(make_step(8));
    send_command(make_cmd(aabb_pkg::CMD_READ, 0));
    send_command(make_cmd(CMD_NONE, 0));
    send_command(make_step(0));
    send_command(make_step(3));
    send_command(make_box(0, -(10 << 16), 0, 2 << 16, 2 << 16, 1 << 16, 1 << 16,
                          1'b0, 1'b0));
    send_command(make_cmd(aabb_pkg::CMD_READ, 0));
    send_command(make_step(8));
    send_command(make_cmd(aabb_pkg::CMD_READ, 7));
  endtask

  task automatic test_random_traffic();
    int done, sel, pre;
    box_cmd_t c;
    done = 0;
    while (done < 16) begin
      pre = written_prefix();
      sel = $urandom_range(0, 99);
      if (pre == 0 || sel < 40) begin
        c = random_box($urandom_range(0, (pre < 15) ? pre : 15));
      end else if (sel < 65) begin
        c = make_step($urandom_range(0, pre));
      end else if (sel < 90) begin
        c = make_cmd(aabb_pkg::CMD_READ, $urandom_range(0, pre - 1));
      end else begin
        c = random_box($urandom_range(0, 63));
        c.cmd = CMD_NONE;
        c.cnt = 7'($urandom);
      end
      send_command(c);
      if (c.cmd != CMD_NONE) done++;
    end
  endtask

  task automatic test_full_table();
    box_cmd_t c;
    for (int k = 0; k < NBOX; k++) send_command(random_box(k));
    send_command(make_step(NBOX));
    c = make_step($urandom_range(NBOX + 1, 127));
    send_command(c);
    send_command(make_step(127));
    send_command(make_cmd(aabb_pkg::CMD_READ, 63));
  endtask

  initial begin
    foreach (box_written[k]) box_written[k] = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edges_and_bounce();
    test_random_traffic();
    test_full_table();
    start <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d transactions sent, %0d of them steps; %0d entry reports checked",
             items_sent, steps_sent, reports_seen);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("** aabb_move_and_collide_pass: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** aabb_move_and_collide_pass: FAILED **");
    end
    $finish;
  end

endmodule
